FILE: rtl/ssr_pkg.sv
// Shared types and constants for the stream search-and-replace block.
// No dependencies; every other file imports this package.
package ssr_pkg;

	localparam int MaxWord = 16;
	localparam int IdxW    = $clog2(MaxWord);
	localparam int FillW   = $clog2(MaxWord + 1);

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PAT_LO  = 3'd0,
		REG_PAT_HI  = 3'd1,
		REG_PAT_LEN = 3'd2,
		REG_REP_LO  = 3'd3,
		REG_REP_HI  = 3'd4,
		REG_REP_LEN = 3'd5
	} reg_idx_t;

	// source of an emitted result
	typedef enum logic [1:0] {
		SRC_REPL = 2'd0,
		SRC_WIN  = 2'd1,
		SRC_MARK = 2'd2
	} src_t;

	typedef enum logic [0:0] {
		OP_CHAR = 1'b0,
		OP_EOL  = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		KIND_CHAR = 1'b0,
		KIND_MARK = 1'b1
	} kind_t;

	typedef struct packed {
		logic load;   // write the accepted character into the window
		logic emit;   // load the output register
		src_t src;
		logic last;
	} ssr_cmd_t;

	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
		logic full;       // window holds pattern-length bytes
		logic match;      // window equals the pattern
		logic repl_last;  // replacement index at its final byte
		logic fill_one;
		logic fill_zero;
	} ssr_status_t;

	// lengths of 0 act as 1, above MaxWord act as MaxWord
	function automatic logic [FillW-1:0] clamp_len(input logic [4:0] v);
		logic [FillW-1:0] r;
		if (v == 5'd0)
			r = FillW'(1);
		else if (v > 5'(MaxWord))
			r = FillW'(MaxWord);
		else
			r = FillW'(v);
		return r;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

FILE: rtl/ssr_ifs.sv
// Valid/ready stream interfaces for the input and result channels.
// Depends on ssr_pkg.
interface ssr_in_if import ssr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] text_char;

	modport source (output valid, op, text_char, input ready);
	modport sink   (input valid, op, text_char, output ready);
endinterface

interface ssr_out_if import ssr_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  out_char;
	logic [15:0] line_replacements;
	logic [15:0] line_length;
	logic        last_of_run;

	modport source (output valid, kind, out_char, line_replacements, line_length,
		last_of_run, input ready);
	modport sink   (input valid, kind, out_char, line_replacements, line_length,
		last_of_run, output ready);
endinterface

FILE: rtl/ssr_datapath.sv
// Datapath: config registers, pending window shift line, line counters,
// pattern compare and the output register. Depends on ssr_pkg, ssr_ifs.
module ssr_datapath import ssr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [63:0]       wr_data,
	input  logic [7:0]        text_char,
	input  ssr_cmd_t          cmd,
	output ssr_status_t       status,
	ssr_out_if.source         dst
);

	logic [MaxWord-1:0][7:0] pat_q;
	logic [MaxWord-1:0][7:0] rep_q;
	logic [FillW-1:0]        plen_q;
	logic [FillW-1:0]        rlen_q;

	logic [7:0]              win_q [MaxWord];
	logic [FillW-1:0]        fill_q;
	logic [IdxW-1:0]         idx_q;
	logic [15:0]             reps_q;
	logic [15:0]             emits_q;

	logic                    ov_q;
	logic                    okind_q;
	logic [7:0]              ochar_q;
	logic [15:0]             oreps_q;
	logic [15:0]             olen_q;
	logic                    olast_q;

	logic [MaxWord-1:0]      byte_ok;
	logic                    out_free;
	logic                    repl_done;
	logic                    char_emit;
	logic [FillW-1:0]        rlen_m1;

	assign out_free  = !ov_q || dst.ready;
	assign rlen_m1   = rlen_q - FillW'(1);
	assign repl_done = cmd.emit && (cmd.src == SRC_REPL) && cmd.last;
	assign char_emit = cmd.emit && (cmd.src != SRC_MARK);

	always_comb begin
		for (int i = 0; i < MaxWord; i++) begin
			byte_ok[i] = (FillW'(i) >= plen_q) || (win_q[i] == pat_q[i]);
		end
	end

	assign status.out_free  = out_free;
	assign status.full      = fill_q >= plen_q;
	assign status.match     = &byte_ok;
	assign status.repl_last = idx_q == rlen_m1[IdxW-1:0];
	assign status.fill_one  = fill_q == FillW'(1);
	assign status.fill_zero = fill_q == '0;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			rep_q  <= '0;
			plen_q <= FillW'(1);
			rlen_q <= FillW'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_PAT_LO:  pat_q[7:0]  <= wr_data;
				REG_PAT_HI:  pat_q[15:8] <= wr_data;
				REG_PAT_LEN: plen_q      <= clamp_len(wr_data[4:0]);
				REG_REP_LO:  rep_q[7:0]  <= wr_data;
				REG_REP_HI:  rep_q[15:8] <= wr_data;
				REG_REP_LEN: rlen_q      <= clamp_len(wr_data[4:0]);
				default: ;
			endcase
		end
	end

	// window contents need no reset: only entries below fill are read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[fill_q[IdxW-1:0]] <= text_char;
		end else if (cmd.emit && cmd.src == SRC_WIN) begin
			for (int i = 0; i < MaxWord - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			idx_q   <= '0;
			reps_q  <= '0;
			emits_q <= '0;
		end else begin
			if (wr_en && wr_index == REG_PAT_LEN)
				fill_q <= '0;
			else if (cmd.load)
				fill_q <= fill_q + FillW'(1);
			else if (cmd.emit && cmd.src == SRC_WIN)
				fill_q <= fill_q - FillW'(1);
			else if (repl_done)
				fill_q <= '0;

			if (repl_done)
				idx_q <= '0;
			else if (cmd.emit && cmd.src == SRC_REPL)
				idx_q <= idx_q + IdxW'(1);

			if (cmd.emit && cmd.src == SRC_MARK) begin
				reps_q  <= '0;
				emits_q <= '0;
			end else begin
				if (char_emit)
					emits_q <= sat_inc(emits_q);
				if (repl_done)
					reps_q <= sat_inc(reps_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (dst.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			olast_q <= cmd.last;
			case (cmd.src)
				SRC_REPL: begin
					okind_q <= KIND_CHAR;
					ochar_q <= rep_q[idx_q];
					oreps_q <= '0;
					olen_q  <= '0;
				end
				SRC_WIN: begin
					okind_q <= KIND_CHAR;
					ochar_q <= win_q[0];
					oreps_q <= '0;
					olen_q  <= '0;
				end
				default: begin
					okind_q <= KIND_MARK;
					ochar_q <= '0;
					oreps_q <= reps_q;
					olen_q  <= emits_q;
				end
			endcase
		end
	end

	assign dst.valid             = ov_q;
	assign dst.kind              = okind_q;
	assign dst.out_char          = ochar_q;
	assign dst.line_replacements = oreps_q;
	assign dst.line_length       = olen_q;
	assign dst.last_of_run       = olast_q;

endmodule

FILE: rtl/ssr_ctrl.sv
// Controller: sequences window load, match decision, replacement burst,
// end-of-line flush and marker. Depends on ssr_pkg.
module ssr_ctrl import ssr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_op,
	output logic        in_ready,
	input  ssr_status_t status,
	output ssr_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_REPL  = 5'b00100,
		S_FLUSH = 5'b01000,
		S_MARK  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '{load: 1'b0, emit: 1'b0, src: SRC_WIN, last: 1'b0};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_CHAR) begin
						cmd.load = 1'b1;
						state_d  = S_CHECK;
					end else begin
						state_d = status.fill_zero ? S_MARK : S_FLUSH;
					end
				end
			end
			S_CHECK: begin
				if (!status.full) begin
					state_d = S_IDLE;
				end else if (status.match) begin
					state_d = S_REPL;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_WIN;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_REPL: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_REPL;
					cmd.last = status.repl_last;
					if (status.repl_last)
						state_d = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_WIN;
					if (status.fill_one)
						state_d = S_MARK;
				end
			end
			S_MARK: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_MARK;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/stream_search_replace.sv
// Top level of the streaming search-and-replace block.
// Depends on ssr_pkg, ssr_ifs, ssr_ctrl, ssr_datapath.
//
//  channel    dir  handshake      payload
//  text_in    in   valid/ready    op, text_char
//  text_out   out  valid/ready    kind, out_char, line_replacements,
//                                 line_length, last_of_run
//  wr_*       in   wr_en only     wr_index, wr_data (64 bits)
//
// A character is accepted, then compared against the window; a match then
// emits the replacement bytes in turn. End of line is accepted, then the
// pending bytes and the marker are emitted.
// Input is taken only while the controller is idle; a full output register
// that is not drained stalls emission. Reset is asynchronous, active low,
// and leaves an empty window with zeroed line counters.
module stream_search_replace import ssr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ssr_in_if.sink      text_in,
	ssr_out_if.source   text_out,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data
);

	ssr_cmd_t    cmd;
	ssr_status_t status;

	ssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_op    (text_in.op),
		.in_ready (text_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ssr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.text_char (text_in.text_char),
		.cmd       (cmd),
		.status    (status),
		.dst       (text_out)
	);

endmodule

FILE: tb/tb_stream_search_replace.sv
// Testbench for stream_search_replace: a directed table, then random text lines,
// every result checked in order against the table's value or an in-bench predictor.
// Depends on ssr_pkg, ssr_ifs (ssr_in_if, ssr_out_if) and the block's RTL.
`timescale 1ns / 100ps

module tb_stream_search_replace;
	import ssr_pkg::*;

	localparam int          RESET_CYCLES = 9;
	localparam int          SETTLE       = 8;
	localparam int          PHASES       = 8;
	localparam int          PHASE_ITEMS  = 32;
	localparam int unsigned LIMIT        = 3_000_000;

	// register indexes the block does not decode
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [15:0] reps;
		logic [15:0] len;
		logic        last;
	} out_item_t;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t   what;
		logic [2:0]  idx;
		logic [63:0] data;
		op_t         op;
		logic [7:0]  ch;
		logic        typed;
		out_item_t   want;
	} dir_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [63:0] wr_data;

	ssr_in_if  text_in_ch ();
	ssr_out_if text_out_ch ();

	stream_search_replace u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in_ch),
		.text_out (text_out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #10 clk = ~clk;

	// predictor state and its copy of the registers
	logic [63:0] cfg_pat_lo  = '0;
	logic [63:0] cfg_pat_hi  = '0;
	logic [4:0]  cfg_pat_len = 5'd1;
	logic [63:0] cfg_rep_lo  = '0;
	logic [63:0] cfg_rep_hi  = '0;
	logic [4:0]  cfg_rep_len = 5'd1;
	logic [7:0]  win [MaxWord];
	int          fill = 0;
	logic [15:0] line_reps = '0;
	logic [15:0] line_len = '0;

	out_item_t   step_out [$];
	out_item_t   out_due [$];
	dir_row_t    dir_rows [$];

	int          mismatches = 0;
	int          burst_left = 0;
	bit          quiet = 1'b1;
	int unsigned cycle_count = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;

	function automatic int eff_len(input logic [4:0] v);
		if (v == 5'd0)
			return 1;
		if (v > 5'(MaxWord))
			return MaxWord;
		return int'(v);
	endfunction

	function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [63:0] hi,
		input int i);
		if (i < 8)
			return lo[8*i +: 8];
		return hi[8*(i-8) +: 8];
	endfunction

	function automatic logic [15:0] bump16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic out_item_t mk_item(input kind_t kind, input logic [7:0] ch,
		input logic [15:0] reps, input logic [15:0] len, input logic last);
		out_item_t r;
		r.kind = kind;
		r.ch   = ch;
		r.reps = reps;
		r.len  = len;
		r.last = last;
		return r;
	endfunction

	// mostly short lengths, with 16, 0 and above-16 mixed in
	function automatic logic [4:0] pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 5'($urandom_range(1, 4));
		if (r == 7)
			return 5'd16;
		if (r == 8)
			return 5'd0;
		return 5'($urandom_range(17, 31));
	endfunction

	function automatic void add_write(input logic [2:0] idx, input logic [63:0] data);
		dir_row_t r;
		r = '0;
		r.what = ROW_WRITE;
		r.idx  = idx;
		r.data = data;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_item(input op_t op, input logic [7:0] ch);
		dir_row_t r;
		r = '0;
		r.what = ROW_ITEM;
		r.op   = op;
		r.ch   = ch;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_typed(input op_t op, input logic [7:0] ch,
		input out_item_t want);
		dir_row_t r;
		r = '0;
		r.what  = ROW_ITEM;
		r.op    = op;
		r.ch    = ch;
		r.typed = 1'b1;
		r.want  = want;
		dir_rows.push_back(r);
	endfunction

	function automatic void apply_write(input logic [2:0] idx, input logic [63:0] data);
		case (idx)
			REG_PAT_LO: cfg_pat_lo = data;
			REG_PAT_HI: cfg_pat_hi = data;
			REG_PAT_LEN: begin
				cfg_pat_len = data[4:0];
				fill = 0;   // pending bytes are dropped, counters kept
			end
			REG_REP_LO: cfg_rep_lo = data;
			REG_REP_HI: cfg_rep_hi = data;
			REG_REP_LEN: cfg_rep_len = data[4:0];
			default: ;
		endcase
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		step_out.push_back(mk_item(KIND_CHAR, b, 16'd0, 16'd0, 1'b0));
		line_len = bump16(line_len);
	endfunction

	// results of one accepted item, left in step_out
	function automatic void replace_step(input op_t op, input logic [7:0] ch);
		int plen;
		int rlen;
		int i;
		bit hit;
		out_item_t tail;
		step_out.delete();
		plen = eff_len(cfg_pat_len);
		rlen = eff_len(cfg_rep_len);
		if (op == OP_CHAR) begin
			win[fill] = ch;
			fill++;
			if (fill >= plen) begin
				hit = 1'b1;
				for (i = 0; i < plen; i++)
					if (win[i] !== pick_byte(cfg_pat_lo, cfg_pat_hi, i))
						hit = 1'b0;
				if (hit) begin
					for (i = 0; i < rlen; i++)
						emit_byte(pick_byte(cfg_rep_lo, cfg_rep_hi, i));
					line_reps = bump16(line_reps);
					fill = 0;
				end else begin
					emit_byte(win[0]);
					for (i = 0; i < fill - 1; i++)
						win[i] = win[i+1];
					fill--;
				end
			end
		end else begin
			for (i = 0; i < fill; i++)
				emit_byte(win[i]);
			fill = 0;
			step_out.push_back(mk_item(KIND_MARK, 8'h00, line_reps, line_len, 1'b0));
			line_reps = '0;
			line_len  = '0;
		end
		if (step_out.size() > 0) begin
			tail = step_out.pop_back();
			tail.last = 1'b1;
			step_out.push_back(tail);
		end
	endfunction

	// hold the input off until every expected result is in and the block settles
	task automatic drain();
		text_in_ch.valid <= 1'b0;
		wr_en <= 1'b0;
		while (out_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		quiet = 1'b1;
	endtask

	// wr_en stays high on return; the next item or drain lowers it
	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
		if (!quiet)
			drain();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		apply_write(idx, data);
	endtask

	task automatic send_item(input op_t op, input logic [7:0] ch, input bit typed,
		input out_item_t want);
		int gap;
		wr_en <= 1'b0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				text_in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		quiet = 1'b0;
		text_in_ch.valid     <= 1'b1;
		text_in_ch.op        <= op;
		text_in_ch.text_char <= ch;
		@(posedge clk);
		while (!text_in_ch.ready)
			@(posedge clk);
		replace_step(op, ch);
		if (typed)
			out_due.push_back(want);
		else
			foreach (step_out[i])
				out_due.push_back(step_out[i]);
	endtask

	// receiver stall pattern, picked at random from four modes
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 64);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   text_out_ch.ready <= 1'b1;
			RX_COIN:   text_out_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: text_out_ch.ready <= ($urandom_range(0, 3) == 0);
			default:   text_out_ch.ready <= ~text_out_ch.ready;
		endcase
	end

	always @(posedge clk) begin : result_check
		out_item_t got;
		out_item_t want;
		if (arst_n && text_out_ch.valid && text_out_ch.ready) begin
			got = mk_item(kind_t'(text_out_ch.kind), text_out_ch.out_char,
				text_out_ch.line_replacements, text_out_ch.line_length,
				text_out_ch.last_of_run);
			if (out_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none,", $time,
					" actual kind %0d char %h reps %0d len %0d last %0b",
					got.kind, got.ch, got.reps, got.len, got.last);
			end else begin
				want = out_due.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: mismatch:", $time,
						" expected kind %0d char %h reps %0d len %0d last %0b,",
						want.kind, want.ch, want.reps, want.len, want.last,
						" actual kind %0d char %h reps %0d len %0d last %0b",
						got.kind, got.ch, got.reps, got.len, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				out_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int          phase;
		int          sent;
		int          segs;
		int          s;
		int          r;
		int          n;
		int          k;
		int          plen;
		logic [7:0]  alpha [3];
		logic [63:0] vals [6];
		logic [2:0]  order [6];
		logic [2:0]  t;
		dir_row_t    row;

		arst_n               = 1'b0;
		wr_en                = 1'b0;
		wr_index             = '0;
		wr_data              = '0;
		text_in_ch.valid     = 1'b0;
		text_in_ch.op        = OP_CHAR;
		text_in_ch.text_char = '0;
		text_out_ch.ready    = 1'b0;
		foreach (win[i])
			win[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// after reset: pattern and replacement are a single zero byte
		add_typed(OP_EOL, 8'h00, mk_item(KIND_MARK, 8'h00, 16'd0, 16'd0, 1'b1));
		add_typed(OP_CHAR, 8'h00, mk_item(KIND_CHAR, 8'h00, 16'd0, 16'd0, 1'b1));
		add_typed(OP_CHAR, 8'hFF, mk_item(KIND_CHAR, 8'hFF, 16'd0, 16'd0, 1'b1));
		add_typed(OP_EOL, 8'h00, mk_item(KIND_MARK, 8'h00, 16'd1, 16'd2, 1'b1));
		// length 0 acts as 1, length 31 acts as 16
		add_write(REG_PAT_LO, 64'hA5C3_0F1E_2D3C_4BFF);
		add_write(REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
		add_write(REG_REP_LO, 64'h0123_4567_89AB_CDEF);
		add_write(REG_REP_HI, 64'hFEDC_BA98_7654_3210);
		add_write(REG_REP_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(OP_CHAR, 8'hFF);
		add_typed(OP_CHAR, 8'h00, mk_item(KIND_CHAR, 8'h00, 16'd0, 16'd0, 1'b1));
		add_write(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
		add_write(REG_SPARE_B, 64'h0000_0000_0000_0001);
		add_item(OP_CHAR, 8'hFF);
		add_typed(OP_EOL, 8'h00, mk_item(KIND_MARK, 8'h00, 16'd2, 16'd33, 1'b1));
		// "ab" -> "XYZ"
		add_write(REG_PAT_LO, 64'h6261);
		add_write(REG_PAT_LEN, 64'd2);
		add_write(REG_REP_LO, 64'h5A5958);
		add_write(REG_REP_LEN, 64'd3);
		add_item(OP_CHAR, 8'h61);
		add_typed(OP_CHAR, 8'h61, mk_item(KIND_CHAR, 8'h61, 16'd0, 16'd0, 1'b1));
		add_item(OP_CHAR, 8'h62);
		add_item(OP_CHAR, 8'h63);
		add_item(OP_EOL, 8'h00);
		// rewriting the pattern length drops the pending 'a'
		add_item(OP_CHAR, 8'h61);
		add_write(REG_PAT_LEN, 64'd16);
		add_typed(OP_EOL, 8'h00, mk_item(KIND_MARK, 8'h00, 16'd0, 16'd0, 1'b1));
		add_write(REG_PAT_HI, 64'hFFEE_DDCC_BBAA_9988);
		add_item(OP_CHAR, 8'hFF);
		add_item(OP_EOL, 8'h00);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.what == ROW_WRITE)
				cfg_write(row.idx, row.data);
			else
				send_item(row.op, row.ch, row.typed, row.want);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			for (k = 0; k < 3; k++)
				alpha[k] = 8'($urandom_range(0, 255));
			vals[REG_PAT_LO] = '0;
			vals[REG_PAT_HI] = '0;
			for (k = 0; k < 16; k++)
				if (k < 8)
					vals[REG_PAT_LO][8*k +: 8] = alpha[$urandom_range(0, 2)];
				else
					vals[REG_PAT_HI][8*(k-8) +: 8] = alpha[$urandom_range(0, 2)];
			vals[REG_REP_LO]  = {32'($urandom), 32'($urandom)};
			vals[REG_REP_HI]  = {32'($urandom), 32'($urandom)};
			vals[REG_PAT_LEN] = {32'($urandom), 27'($urandom), pick_len()};
			vals[REG_REP_LEN] = {32'($urandom), 27'($urandom), pick_len()};
			if (phase == 0) begin
				vals[REG_PAT_LEN][4:0] = 5'd16;
				vals[REG_REP_LEN][4:0] = 5'd16;
			end else if (phase == 1) begin
				vals[REG_PAT_LEN][4:0] = 5'd0;
				vals[REG_REP_LEN][4:0] = 5'd0;
			end
			for (k = 0; k < 6; k++)
				order[k] = 3'(k);
			for (k = 5; k > 0; k--) begin
				n = $urandom_range(0, k);
				t = order[k];
				order[k] = order[n];
				order[n] = t;
			end
			for (k = 0; k < 6; k++)
				cfg_write(order[k], vals[order[k]]);
			if ($urandom_range(0, 2) == 0)
				cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					{32'($urandom), 32'($urandom)});

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				segs = $urandom_range(0, 6);
				for (s = 0; s < segs; s++) begin
					if ($urandom_range(0, 15) == 0)
						cfg_write(REG_PAT_LEN, {32'($urandom), 27'($urandom), pick_len()});
					plen = eff_len(cfg_pat_len);
					r = $urandom_range(0, 99);
					if (r < 45) begin
						for (k = 0; k < plen; k++)
							send_item(OP_CHAR, pick_byte(cfg_pat_lo, cfg_pat_hi, k), 1'b0, '0);
						sent += plen;
					end else if (r < 65) begin
						// broken occurrence: a proper prefix of the pattern, or all of a one-byte pattern
						n = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
						for (k = 0; k < n; k++)
							send_item(OP_CHAR, pick_byte(cfg_pat_lo, cfg_pat_hi, k), 1'b0, '0);
						sent += n;
					end else if (r < 90) begin
						send_item(OP_CHAR, alpha[$urandom_range(0, 2)], 1'b0, '0);
						sent++;
					end else begin
						send_item(OP_CHAR, 8'($urandom_range(0, 255)), 1'b0, '0);
						sent++;
					end
				end
				send_item(OP_EOL, 8'($urandom_range(0, 255)), 1'b0, '0);
				sent++;
			end
		end

		drain();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
